// File: design/sal_pkg.sv
package sal_pkg;

  localparam int POOL_DEPTH    = 8;
  localparam int PAYLOAD_WIDTH = 64;
  localparam int KEY_W         = 32;
  localparam int SLOT_FIELD_W  = 3;
  localparam int LINK_W        = $clog2(POOL_DEPTH + 1);
  localparam int SLOT_W        = $clog2(POOL_DEPTH);

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [KEY_W-1:0]  key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } sal_in_t;

  typedef struct packed {
    logic                    accepted;
    logic                    found;
    logic [SLOT_FIELD_W-1:0] slot;
  } sal_out_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic splice;
    logic load_out;
    logic link_sel_fresh;
  } sal_cmd_t;

  typedef struct packed {
    logic walk_stop;
    logic is_insert;
    logic refused;
    logic out_full;
  } sal_sts_t;

  // Reported slot is the link value cut or widened to the output field.
  function automatic logic [SLOT_FIELD_W-1:0] to_slot(input logic [LINK_W-1:0] link);
    logic [LINK_W+SLOT_FIELD_W-1:0] wide;
    wide = {SLOT_FIELD_W'(0), link};
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage

// File: design/sal_datapath.sv
module sal_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sal_pkg::sal_in_t  in_data,
  input  sal_pkg::sal_cmd_t cmd,
  input  logic              out_stall,
  output sal_pkg::sal_sts_t sts,
  output logic              out_valid,
  output sal_pkg::sal_out_t out_data
);

  localparam int D  = sal_pkg::POOL_DEPTH;
  localparam int LW = sal_pkg::LINK_W;
  localparam int SW = sal_pkg::SLOT_W;

  logic signed [sal_pkg::KEY_W-1:0]  keys_r  [D];
  logic [sal_pkg::PAYLOAD_WIDTH-1:0] pays_r  [D];
  logic [LW-1:0]                     links_r [D];

  logic [LW-1:0] head_r, free_r, cur_r, prev_r, steps_r, fresh_r;
  logic          kind_r, refused_r, out_valid_r;
  logic signed [sal_pkg::KEY_W-1:0]  key_r;
  logic [sal_pkg::PAYLOAD_WIDTH-1:0] pay_r;
  sal_pkg::sal_out_t                 out_r;

  logic [LW-1:0] link_addr, link_rd, follow_nxt;
  logic          cur_null, key_hit, key_less;
  logic signed [sal_pkg::KEY_W-1:0] key_rd;
  sal_pkg::sal_out_t res;

  assign link_addr = cmd.link_sel_fresh ? fresh_r : cur_r;
  assign link_rd   = links_r[link_addr[SW-1:0]];
  // A null pointer or a damaged link both end the walk.
  assign follow_nxt = (link_addr >= sal_pkg::LINK_NULL || link_rd >= sal_pkg::LINK_NULL) ?
                      sal_pkg::LINK_NULL : link_rd;

  assign cur_null = cur_r >= sal_pkg::LINK_NULL;
  assign key_rd   = keys_r[cur_r[SW-1:0]];
  assign key_hit  = key_rd == key_r;
  assign key_less = key_rd < key_r;

  always_comb begin
    sts.is_insert = kind_r == sal_pkg::KIND_INSERT;
    sts.refused   = refused_r;
    sts.out_full  = out_valid_r && out_stall;
    sts.walk_stop = cur_null || steps_r == sal_pkg::LINK_NULL ||
                    (kind_r == sal_pkg::KIND_SEARCH ? key_hit : !key_less);
  end

  always_comb begin
    res = '0;
    if (kind_r == sal_pkg::KIND_SEARCH) begin
      if (!cur_null && key_hit) begin
        res.found = 1'b1;
        res.slot  = sal_pkg::to_slot(cur_r);
      end
    end else if (!refused_r) begin
      res.accepted = 1'b1;
      res.slot     = sal_pkg::to_slot(fresh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= sal_pkg::LINK_NULL;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < D; i++) begin
        links_r[i] <= LW'(i + 1);
      end
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.splice) begin
        free_r <= follow_nxt;
        if (prev_r >= sal_pkg::LINK_NULL) begin
          head_r <= fresh_r;
        end else begin
          links_r[prev_r[SW-1:0]] <= fresh_r;
        end
        links_r[fresh_r[SW-1:0]] <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_data.kind;
      key_r     <= in_data.key;
      pay_r     <= in_data.payload;
      cur_r     <= (head_r >= sal_pkg::LINK_NULL) ? sal_pkg::LINK_NULL : head_r;
      prev_r    <= sal_pkg::LINK_NULL;
      steps_r   <= '0;
      fresh_r   <= free_r;
      refused_r <= in_data.kind == sal_pkg::KIND_INSERT && free_r >= sal_pkg::LINK_NULL;
    end else if (cmd.step) begin
      prev_r  <= cur_r;
      cur_r   <= follow_nxt;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.splice) begin
      keys_r[fresh_r[SW-1:0]] <= key_r;
      pays_r[fresh_r[SW-1:0]] <= pay_r;
    end
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/sal_controller.sv
module sal_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sal_pkg::sal_sts_t sts,
  output logic              in_stall,
  output sal_pkg::sal_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_SPLICE = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.refused) begin
          state_nxt = S_FIN;
        end else if (sts.walk_stop) begin
          state_nxt = sts.is_insert ? S_SPLICE : S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SPLICE: begin
        cmd.splice         = 1'b1;
        cmd.link_sel_fresh = 1'b1;
        state_nxt          = S_FIN;
      end
      S_FIN: begin
        // Wait until the output register is free or being emptied.
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/sorted_array_linked_list.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    kind, key, payload (sal_in_t)
// out_     output     out_valid/out_stall  accepted, found, slot (sal_out_t)
//
// One transaction at a time: accept, walk one list entry per cycle (up to
// POOL_DEPTH entries), splice the new entry in for inserts, then load the
// result once the output register is free or being emptied.
// Reset is synchronous; the free list is chained and the list is empty at once.
// A stalled result waits in the output register while the next transaction
// is taken and walked; that next result is held back until the register drains.
module sorted_array_linked_list (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sal_pkg::sal_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sal_pkg::sal_out_t out_data
);

  sal_pkg::sal_cmd_t cmd;
  sal_pkg::sal_sts_t sts;

  sal_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sal_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 2 * (sal_pkg::POOL_DEPTH + 4);
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 250;
  localparam int REPORT_MAX   = 10;
  localparam int SW           = sal_pkg::SLOT_W;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  sal_pkg::sal_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sal_pkg::sal_out_t out_data;

  sorted_array_linked_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the pool: sorted list and free list.
  logic signed [sal_pkg::KEY_W-1:0]  rec_key     [sal_pkg::POOL_DEPTH];
  logic [sal_pkg::PAYLOAD_WIDTH-1:0] rec_payload [sal_pkg::POOL_DEPTH];
  logic [sal_pkg::LINK_W-1:0]        rec_next    [sal_pkg::POOL_DEPTH];
  logic [sal_pkg::LINK_W-1:0]        list_head;
  logic [sal_pkg::LINK_W-1:0]        free_head;

  sal_pkg::sal_in_t                  request_q[$];
  sal_pkg::sal_out_t                 due_results[$];
  logic signed [sal_pkg::KEY_W-1:0]  stored_keys[$];

  int   request_total  = 0;
  int   requests_taken = 0;
  int   results_seen   = 0;
  int   mismatch_count = 0;
  int   send_gap       = 0;
  int   hold_left      = 0;
  int   idle_cycles    = 0;
  logic offering;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic sal_pkg::sal_out_t apply_to_list(sal_pkg::sal_in_t item);
    sal_pkg::sal_out_t          res;
    logic [sal_pkg::LINK_W-1:0] prev;
    logic [sal_pkg::LINK_W-1:0] cur;
    logic [sal_pkg::LINK_W-1:0] fresh;
    int                         steps;
    res   = '0;
    prev  = sal_pkg::LINK_NULL;
    cur   = list_head;
    steps = 0;
    if (item.kind == sal_pkg::KIND_SEARCH) begin
      while (cur != sal_pkg::LINK_NULL && rec_key[cur[SW-1:0]] != item.key
             && steps < sal_pkg::POOL_DEPTH) begin
        cur = rec_next[cur[SW-1:0]];
        steps++;
      end
      if (cur != sal_pkg::LINK_NULL && rec_key[cur[SW-1:0]] == item.key) begin
        res.found = 1'b1;
        res.slot  = sal_pkg::SLOT_FIELD_W'(cur);
      end
      return res;
    end
    if (free_head == sal_pkg::LINK_NULL) begin
      return res;
    end
    fresh = free_head;
    // Stop at the first key not below the new one, so duplicates go in front.
    while (cur != sal_pkg::LINK_NULL
           && $signed(rec_key[cur[SW-1:0]]) < $signed(item.key)
           && steps < sal_pkg::POOL_DEPTH) begin
      prev = cur;
      cur  = rec_next[cur[SW-1:0]];
      steps++;
    end
    free_head = rec_next[fresh[SW-1:0]];
    if (prev == sal_pkg::LINK_NULL) begin
      list_head = fresh;
    end else begin
      rec_next[prev[SW-1:0]] = fresh;
    end
    rec_key[fresh[SW-1:0]]     = item.key;
    rec_payload[fresh[SW-1:0]] = item.payload;
    rec_next[fresh[SW-1:0]]    = cur;
    res.accepted = 1'b1;
    res.slot     = sal_pkg::SLOT_FIELD_W'(fresh);
    return res;
  endfunction

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_item(logic kind, logic signed [sal_pkg::KEY_W-1:0] key,
                            logic [sal_pkg::PAYLOAD_WIDTH-1:0] payload);
    sal_pkg::sal_in_t item;
    item.kind    = kind;
    item.key     = key;
    item.payload = payload;
    request_q.push_back(item);
    if (kind == sal_pkg::KIND_INSERT && stored_keys.size() < sal_pkg::POOL_DEPTH) begin
      stored_keys.push_back(key);
    end
  endtask

  task automatic note_mismatch(string what, sal_pkg::sal_out_t want,
                               sal_pkg::sal_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t: %s: expected accepted=%0d found=%0d slot=%0d,",
               $realtime, what, want.accepted, want.found, want.slot,
               " got accepted=%0d found=%0d slot=%0d",
               got.accepted, got.found, got.slot);
    end
  endtask

  // Sender: one transaction offered at a time, random gap after each acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_to_list(in_data));
        requests_taken++;
        offering = 1'b0;
        send_gap = (((requests_taken / 80) % 4) == 3) ? 0 : $urandom_range(0, 12);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls for a random count afterwards.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result", '0, out_data);
        end else begin
          if (out_data.accepted !== due_results[0].accepted
              || out_data.found !== due_results[0].found
              || out_data.slot !== due_results[0].slot) begin
            note_mismatch("result mismatch", due_results[0], out_data);
          end
          void'(due_results.pop_front());
        end
        // One long hold-off lets the block fill up and push back on its input.
        if (results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end else if (((results_seen / 70) % 5) == 4) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 12);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int                               pick;
    logic signed [sal_pkg::KEY_W-1:0] k;

    for (int i = 0; i < sal_pkg::POOL_DEPTH; i++) begin
      rec_key[i]     = '0;
      rec_payload[i] = '0;
      rec_next[i]    = sal_pkg::LINK_W'(i + 1);
    end
    list_head = sal_pkg::LINK_NULL;
    free_head = '0;

    // Directed part: empty list, extreme keys and payloads, duplicates, full pool.
    queue_item(sal_pkg::KIND_SEARCH, 32'sd0, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, 32'sd0, 64'h0);
    queue_item(sal_pkg::KIND_INSERT, 32'sh7fffffff, 64'hffff_ffff_ffff_ffff);
    queue_item(sal_pkg::KIND_INSERT, 32'sh80000000, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, 32'sd0, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, -32'sd1, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, 32'sh7fffffff, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, $urandom, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, 32'sh80000001, rand_word64());
    queue_item(sal_pkg::KIND_INSERT, 32'sd3, 64'ha5a5_5a5a_a5a5_5a5a);
    queue_item(sal_pkg::KIND_SEARCH, 32'sd0, rand_word64());
    queue_item(sal_pkg::KIND_SEARCH, 32'sh7fffffff, 64'h0);
    queue_item(sal_pkg::KIND_SEARCH, 32'sh80000000, 64'hffff_ffff_ffff_ffff);
    queue_item(sal_pkg::KIND_SEARCH, 32'sh80000001, rand_word64());
    queue_item(sal_pkg::KIND_SEARCH, -32'sd1, rand_word64());
    queue_item(sal_pkg::KIND_SEARCH, stored_keys[6], rand_word64());
    queue_item(sal_pkg::KIND_SEARCH, 32'sd3, rand_word64());
    queue_item(sal_pkg::KIND_SEARCH, 32'sh7ffffffe, rand_word64());

    // Random part: mostly searches around the stored keys, some refused inserts.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_item(sal_pkg::KIND_INSERT, $urandom, rand_word64());
      end else begin
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (pick >= 80) begin
          k = $urandom;
        end else if (pick >= 70) begin
          k = k - 1;
        end else if (pick >= 60) begin
          k = k + 1;
        end
        queue_item(sal_pkg::KIND_SEARCH, k, rand_word64());
      end
    end
    request_total = request_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < request_total || due_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
